>>> src/mceed_pkg.sv
// Shared types and constants for the multichannel extremum event detector.
// Used by the top level and the testbench; depends on nothing.
package mceed_pkg;

	// Number of tracked objects and the width of an object address.
	localparam int OBJECTS = 4096;
	localparam int OBJ_AW  = $clog2(OBJECTS);

	// Field widths fixed by the interface.
	localparam int ID_W    = 12;
	localparam int STEP_W  = 16;
	localparam int Q_W     = 32;
	localparam int COUNT_W = 13;

	// Q16.16 reset values of the history.
	localparam logic signed [Q_W-1:0] Q_800 = 32'sd52428800;
	localparam logic signed [Q_W-1:0] Q_900 = 32'sd58982400;

	localparam logic [COUNT_W-1:0] COUNT_MAX   = {COUNT_W{1'b1}};
	localparam logic [ID_W:0]      OBJ_LIMIT   = (ID_W+1)'(OBJECTS);
	localparam logic [STEP_W-1:0]  STEP_MIN    = STEP_W'(2);
	localparam logic signed [Q_W-1:0] MAG_LIMIT_RST = 32'sd786432;

	// Configuration register indexes.
	typedef enum logic [1:0] {
		REG_MAG_LIMIT = 2'd0,
		REG_REPORT    = 2'd1,
		REG_COLLECT   = 2'd2
	} cfg_reg_t;

	// One history entry per object, held in the RAM.
	typedef struct packed {
		logic                  sel;
		logic signed [Q_W-1:0] ang_l;
		logic signed [Q_W-1:0] ang_bl;
		logic signed [Q_W-1:0] dist_l;
		logic signed [Q_W-1:0] dist_bl;
		logic signed [Q_W-1:0] mag_l;
		logic signed [Q_W-1:0] mag_bl;
	} hist_entry_t;

	localparam int ENTRY_W = $bits(hist_entry_t);

	localparam hist_entry_t ENTRY_RST = '{
		sel:     1'b0,
		ang_l:   Q_800,
		ang_bl:  Q_900,
		dist_l:  Q_900,
		dist_bl: Q_800,
		mag_l:   Q_900,
		mag_bl:  Q_800
	};

	// One result as held in the output register.
	typedef struct packed {
		logic [ID_W-1:0]       obj;
		logic                  opp;
		logic                  apo;
		logic                  peak;
		logic                  bright;
		logic                  fresh;
		logic [COUNT_W-1:0]    count;
		logic signed [Q_W-1:0] mag;
		logic signed [Q_W-1:0] edist;
	} result_t;

endpackage

>>> src/mceed_ram.sv
// Generic single-write, single-read synchronous RAM with a registered read.
// Stand-alone; no package dependency.
module mceed_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// A read and a write to the same address in one cycle return the old data.
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

>>> src/multichannel_extremum_event_detector.sv
// Top level of the multichannel extremum event detector.
// Depends on mceed_pkg and on the mceed_ram history memory.
//
// This block takes one sample per request for one of 4096 tracked objects and
// returns exactly one result per sample, in order. After reset the block first
// sweeps its history memory to the reset values, one object per cycle, and
// takes no sample until the sweep is done; configuration writes are taken at
// all times. From then on a new sample is taken in every cycle in which the
// result path can move, so the sustained rate is one sample per clock. A
// sample passes through two registers, stage 1 and the output register; stage 1
// holds while a full output register is not being emptied. Stage 1 is there for
// the per-object history RAM: its read is issued when a sample is taken, the
// data comes back while the sample is in stage 1, where the comparisons and the
// history update happen; the new entry is written back as it leaves. A sample
// for the same object as the one just ahead of it gets the freshly written
// entry from a forwarding register instead of the stale RAM read. A sample is
// "bright" when it is secure, its magnitude is strictly below the limit and its
// step number is above two; only bright samples raise the opposition, apogee
// and peak-brightness flags (and only while reporting is on), and only bright
// samples enter the selection map (while collection is on). A sample that is
// not secure leaves the history untouched.
module multichannel_extremum_event_detector (
	input  logic                              clk,
	input  logic                              arst_n,
	// Configuration write channel.
	input  logic                              cfg_valid,
	output logic                              cfg_ready,
	input  logic [1:0]                        cfg_index,
	input  logic [mceed_pkg::Q_W-1:0]         cfg_data,
	// Sample channel.
	input  logic                              in_valid,
	output logic                              in_ready,
	input  logic [mceed_pkg::ID_W-1:0]        object_id,
	input  logic [mceed_pkg::STEP_W-1:0]      step_index,
	input  logic                              secure,
	input  logic signed [mceed_pkg::Q_W-1:0]  sun_angle,
	input  logic signed [mceed_pkg::Q_W-1:0]  earth_distance,
	input  logic signed [mceed_pkg::Q_W-1:0]  magnitude,
	// Result channel.
	output logic                              out_valid,
	input  logic                              out_ready,
	output logic [mceed_pkg::ID_W-1:0]        result_object,
	output logic                              opposition,
	output logic                              apogee,
	output logic                              peak_brightness,
	output logic                              bright,
	output logic                              newly_selected,
	output logic [mceed_pkg::COUNT_W-1:0]     selected_count,
	output logic signed [mceed_pkg::Q_W-1:0]  reported_magnitude,
	output logic signed [mceed_pkg::Q_W-1:0]  reported_distance
);

	import mceed_pkg::*;

	// Configuration registers.
	logic signed [Q_W-1:0] bright_limit_q;
	logic                  report_q;
	logic                  collect_q;

	// Clearing pass after reset.
	logic              clr_busy_q;
	logic [OBJ_AW-1:0] clr_addr_q;

	// Stage 1: the sample whose history is being read from the RAM.
	logic                  valid_s1;
	logic [ID_W-1:0]       id_s1;
	logic [STEP_W-1:0]     step_s1;
	logic                  secure_s1;
	logic signed [Q_W-1:0] ang_s1;
	logic signed [Q_W-1:0] dist_s1;
	logic signed [Q_W-1:0] mag_s1;

	// Forwarding of the most recent history write.
	logic              fwd_valid_q;
	logic [OBJ_AW-1:0] fwd_addr_q;
	hist_entry_t       fwd_data_q;

	logic [COUNT_W-1:0] count_q;

	// Output register.
	logic    res_valid_q;
	result_t res_q;

	// RAM ports.
	logic              ram_we;
	logic [OBJ_AW-1:0] ram_waddr;
	hist_entry_t       ram_wdata;
	logic [ENTRY_W-1:0] ram_rdata;

	// Stage 1 logic.
	logic               in_fire;
	logic               s1_go;
	logic               act_s1;
	logic               bright_s1;
	logic               fresh_s1;
	logic               report_s1;
	logic [OBJ_AW-1:0]  addr_s1;
	hist_entry_t        cur_s1;
	hist_entry_t        upd_s1;
	logic [COUNT_W-1:0] count_next;
	result_t            res_next;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bright_limit_q <= MAG_LIMIT_RST;
			report_q       <= 1'b0;
			collect_q      <= 1'b1;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				REG_MAG_LIMIT: bright_limit_q <= cfg_data;
				REG_REPORT:    report_q       <= cfg_data[0];
				REG_COLLECT:   collect_q      <= cfg_data[0];
				default: begin
				end
			endcase
		end
	end

	// The clearing pass writes the reset entry to every object in turn.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_busy_q <= 1'b1;
			clr_addr_q <= '0;
		end else if (clr_busy_q) begin
			clr_addr_q <= clr_addr_q + 1'b1;
			if (clr_addr_q == OBJ_AW'(OBJECTS - 1)) begin
				clr_busy_q <= 1'b0;
			end
		end
	end

	// Stage 1 moves on when the output register is empty or being emptied.
	assign s1_go    = valid_s1 && (!res_valid_q || out_ready);
	assign in_ready = !clr_busy_q && (!valid_s1 || s1_go);
	assign in_fire  = in_valid && in_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_fire) begin
			valid_s1 <= 1'b1;
		end else if (s1_go) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire) begin
			id_s1     <= object_id;
			step_s1   <= step_index;
			secure_s1 <= secure;
			ang_s1    <= sun_angle;
			dist_s1   <= earth_distance;
			mag_s1    <= magnitude;
		end
	end

	assign addr_s1 = id_s1[OBJ_AW-1:0];

	// The RAM read may have been issued at the same edge as the previous write, so that
	// write is taken from the forwarding register when the object matches.
	always_comb begin
		if (fwd_valid_q && (fwd_addr_q == addr_s1)) begin
			cur_s1 = fwd_data_q;
		end else begin
			cur_s1 = hist_entry_t'(ram_rdata);
		end
	end

	assign act_s1    = secure_s1 && ({1'b0, id_s1} < OBJ_LIMIT);
	assign bright_s1 = act_s1 && (mag_s1 < bright_limit_q) && (step_s1 > STEP_MIN);
	assign fresh_s1  = bright_s1 && collect_q && !cur_s1.sel;
	assign report_s1 = bright_s1 && report_q;

	always_comb begin
		upd_s1         = cur_s1;
		upd_s1.sel     = cur_s1.sel || fresh_s1;
		upd_s1.ang_bl  = cur_s1.ang_l;
		upd_s1.ang_l   = ang_s1;
		upd_s1.dist_bl = cur_s1.dist_l;
		upd_s1.dist_l  = dist_s1;
		upd_s1.mag_bl  = cur_s1.mag_l;
		upd_s1.mag_l   = mag_s1;
	end

	assign count_next = (fresh_s1 && (count_q != COUNT_MAX)) ? count_q + 1'b1 : count_q;

	always_comb begin
		res_next.obj    = id_s1;
		res_next.opp    = report_s1 && (cur_s1.ang_l > ang_s1) &&
			(cur_s1.ang_l > cur_s1.ang_bl);
		res_next.apo    = report_s1 && (cur_s1.dist_l > dist_s1) &&
			(cur_s1.dist_l > cur_s1.dist_bl);
		res_next.peak   = report_s1 && (cur_s1.mag_l < mag_s1) &&
			(cur_s1.mag_l < cur_s1.mag_bl);
		res_next.bright = bright_s1;
		res_next.fresh  = fresh_s1;
		res_next.count  = count_next;
		res_next.mag    = mag_s1;
		res_next.edist  = dist_s1;
	end

	// Write port: the clearing pass, else the history update of stage 1.
	always_comb begin
		if (clr_busy_q) begin
			ram_we    = 1'b1;
			ram_waddr = clr_addr_q;
			ram_wdata = ENTRY_RST;
		end else begin
			ram_we    = s1_go && act_s1;
			ram_waddr = addr_s1;
			ram_wdata = upd_s1;
		end
	end

	mceed_ram #(
		.WIDTH(ENTRY_W),
		.DEPTH(OBJECTS)
	) u_hist_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (in_fire),
		.raddr (object_id[OBJ_AW-1:0]),
		.rdata (ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fwd_valid_q <= 1'b0;
			count_q     <= '0;
		end else if (!clr_busy_q && ram_we) begin
			fwd_valid_q <= 1'b1;
			count_q     <= count_next;
		end
	end

	always_ff @(posedge clk) begin
		if (!clr_busy_q && ram_we) begin
			fwd_addr_q <= ram_waddr;
			fwd_data_q <= ram_wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (s1_go) begin
			res_valid_q <= 1'b1;
		end else if (out_ready) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_go) begin
			res_q <= res_next;
		end
	end

	assign out_valid          = res_valid_q;
	assign result_object      = res_q.obj;
	assign opposition         = res_q.opp;
	assign apogee             = res_q.apo;
	assign peak_brightness    = res_q.peak;
	assign bright             = res_q.bright;
	assign newly_selected     = res_q.fresh;
	assign selected_count     = res_q.count;
	assign reported_magnitude = res_q.mag;
	assign reported_distance  = res_q.edist;

	// No sample may be in flight while the memory is being cleared.
	a_clear_idle: assert property (@(posedge clk) disable iff (!arst_n)
		clr_busy_q |-> (!in_ready && !valid_s1))
		else $error("sample in flight during the clearing pass");

	// Event flags and new selections only come with a bright sample.
	a_flags_bright: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && (opposition || apogee || peak_brightness || newly_selected))
		|-> bright)
		else $error("event flag without a bright sample");

	// A new selection raises the count by one unless it is saturated.
	a_count_step: assert property (@(posedge clk) disable iff (!arst_n)
		(!clr_busy_q && ram_we && fresh_s1 && (count_q != COUNT_MAX))
		|=> (count_q == $past(count_q) + 1'b1))
		else $error("selection count did not advance");

	// The result taken from stage 1 reports the count that stage 1 left.
	a_count_out: assert property (@(posedge clk) disable iff (!arst_n)
		s1_go |=> (selected_count == count_q))
		else $error("reported count differs from the stored count");

endmodule

>>> dv/multichannel_extremum_event_detector_tb.sv
// Self-checking testbench for the multichannel extremum event detector: directed
// and random samples against a cycle-free predictor of the per-object history.
// Depends on mceed_pkg and the RTL.
`timescale 1ns / 100ps

module multichannel_extremum_event_detector_tb;
	import mceed_pkg::*;

	// Register index that decodes to nothing and must be ignored by the block.
	localparam logic [1:0] REG_UNUSED = 2'd3;

	// One unit in Q16.16.
	localparam int Q_ONE = 65536;

	// Objects followed as coherent tracks during the random part.
	localparam int TRACKS = 6;

	// Cycles with nothing outstanding before a register write is issued.
	localparam int SETTLE_CYCLES = 4;

	// Cycles allowed after the last result before the verdict.
	localparam int TAIL_CYCLES = 10;

	// The receiver holds off once, after this many results, for this many cycles.
	localparam int HOLD_AT_RESULT = 200;
	localparam int HOLD_CYCLES    = 300;

	// Kinds of request the driver takes from its plan.
	typedef enum logic [1:0] {
		REQ_SAMPLE = 2'd0,
		REQ_CONFIG = 2'd1,
		REQ_DRAIN  = 2'd2
	} request_kind_e;

	// Packed in port order so a concatenation of the sample ports fills it.
	typedef struct packed {
		logic [ID_W-1:0]   id;
		logic [STEP_W-1:0] step;
		logic              sec;
		logic [Q_W-1:0]    ang;
		logic [Q_W-1:0]    edist;
		logic [Q_W-1:0]    mag;
	} sample_t;

	typedef struct packed {
		request_kind_e kind;
		sample_t       smp;
		logic [1:0]    idx;
		logic [Q_W-1:0] data;
	} plan_entry_t;

	logic clk    = 1'b0;
	logic arst_n = 1'b0;

	logic                cfg_valid = 1'b0;
	logic                cfg_ready;
	logic [1:0]          cfg_index = '0;
	logic [Q_W-1:0]      cfg_data  = '0;

	logic                in_valid  = 1'b0;
	logic                in_ready;
	logic [ID_W-1:0]     object_id = '0;
	logic [STEP_W-1:0]   step_index = '0;
	logic                secure = 1'b0;
	logic signed [Q_W-1:0] sun_angle = '0;
	logic signed [Q_W-1:0] earth_distance = '0;
	logic signed [Q_W-1:0] magnitude = '0;

	logic                out_valid;
	logic                out_ready = 1'b0;
	logic [ID_W-1:0]     result_object;
	logic                opposition;
	logic                apogee;
	logic                peak_brightness;
	logic                bright;
	logic                newly_selected;
	logic [COUNT_W-1:0]  selected_count;
	logic signed [Q_W-1:0] reported_magnitude;
	logic signed [Q_W-1:0] reported_distance;

	// Everything the driver still has to present, in order: samples, register
	// writes and pauses that wait for the block to run dry.
	plan_entry_t pending_requests[$];

	// Predicted results of accepted samples, oldest first.
	result_t detections_due[$];

	// Shadow of the block's per-object history and selection map.
	logic signed [Q_W-1:0] ang_last  [OBJECTS];
	logic signed [Q_W-1:0] ang_prev  [OBJECTS];
	logic signed [Q_W-1:0] dist_last [OBJECTS];
	logic signed [Q_W-1:0] dist_prev [OBJECTS];
	logic signed [Q_W-1:0] mag_last  [OBJECTS];
	logic signed [Q_W-1:0] mag_prev  [OBJECTS];
	logic                  in_selection [OBJECTS];
	logic [COUNT_W-1:0]    selection_total;

	// Shadow of the configuration registers.
	logic signed [Q_W-1:0] bright_limit;
	logic                  report_on;
	logic                  collect_on;

	// Request counters. Each is written by one clocked process only, with
	// nonblocking assignments, so the other process always reads the value
	// from before the edge.
	int sent_count;
	int got_count;

	int error_count  = 0;
	int config_count = 0;
	int bright_total = 0;
	int fresh_total  = 0;
	int event_total  = 0;

	// Track state used to build well-formed sample sequences.
	logic [ID_W-1:0]   track_obj  [TRACKS];
	logic [STEP_W-1:0] track_step [TRACKS];
	int                track_ang  [TRACKS];
	int                track_dist [TRACKS];

	multichannel_extremum_event_detector i_dut (
		.clk                (clk),
		.arst_n             (arst_n),
		.cfg_valid          (cfg_valid),
		.cfg_ready          (cfg_ready),
		.cfg_index          (cfg_index),
		.cfg_data           (cfg_data),
		.in_valid           (in_valid),
		.in_ready           (in_ready),
		.object_id          (object_id),
		.step_index         (step_index),
		.secure             (secure),
		.sun_angle          (sun_angle),
		.earth_distance     (earth_distance),
		.magnitude          (magnitude),
		.out_valid          (out_valid),
		.out_ready          (out_ready),
		.result_object      (result_object),
		.opposition         (opposition),
		.apogee             (apogee),
		.peak_brightness    (peak_brightness),
		.bright             (bright),
		.newly_selected     (newly_selected),
		.selected_count     (selected_count),
		.reported_magnitude (reported_magnitude),
		.reported_distance  (reported_distance)
	);

	always #1 clk = ~clk;

	// Idle gap after a request: mostly none or short, now and then long. In a
	// calm stretch there is no gap at all, so back-to-back traffic is seen too.
	function automatic int pick_gap(input bit calm);
		int roll;
		if (calm) begin
			return 0;
		end
		roll = $urandom_range(99);
		if (roll < 55) begin
			return 0;
		end
		if (roll < 90) begin
			return $urandom_range(3, 1);
		end
		return $urandom_range(40, 8);
	endfunction

	// Data word for a one-bit register: random upper bits, the wanted bit 0.
	function automatic logic [Q_W-1:0] flag_word(input bit value);
		logic [Q_W-1:0] word;
		word    = $urandom;
		word[0] = value;
		return word;
	endfunction

	// Expected result of one accepted sample. Updates the shadow history, so it
	// must be called exactly once per sample, in acceptance order.
	function automatic result_t predict_detection(input sample_t smp);
		result_t               res;
		logic [ID_W-1:0]       k;
		logic signed [Q_W-1:0] ang;
		logic signed [Q_W-1:0] edist;
		logic signed [Q_W-1:0] mag;
		k     = smp.id;
		ang   = smp.ang;
		edist = smp.edist;
		mag   = smp.mag;
		res       = '0;
		res.obj   = smp.id;
		res.mag   = mag;
		res.edist = edist;
		// A sample that is not secure leaves the history alone and raises nothing.
		if (smp.sec) begin
			if (mag < bright_limit && smp.step > STEP_MIN) begin
				res.bright = 1'b1;
				if (collect_on && !in_selection[k]) begin
					in_selection[k] = 1'b1;
					if (selection_total != COUNT_MAX) begin
						selection_total = selection_total + 1'b1;
					end
					res.fresh = 1'b1;
				end
				// The middle of the last three samples is tested. Distance is a
				// maximum test, the same way round as the angle.
				if (report_on) begin
					res.opp  = ang_last[k] > ang && ang_last[k] > ang_prev[k];
					res.apo  = dist_last[k] > edist && dist_last[k] > dist_prev[k];
					res.peak = mag_last[k] < mag && mag_last[k] < mag_prev[k];
				end
			end
			ang_prev[k]  = ang_last[k];
			ang_last[k]  = ang;
			dist_prev[k] = dist_last[k];
			dist_last[k] = edist;
			mag_prev[k]  = mag_last[k];
			mag_last[k]  = mag;
		end
		res.count = selection_total;
		return res;
	endfunction

	task automatic check_field(input string name, input logic [ID_W-1:0] obj,
			input logic [Q_W-1:0] want, input logic [Q_W-1:0] got);
		if (want !== got) begin
			$display("%0t ns: %s mismatch for object %0d, expected %h, actual %h",
				$time, name, obj, want, got);
			error_count++;
		end
	endtask

	task automatic plan_sample(input logic [ID_W-1:0] id, input logic [STEP_W-1:0] step,
			input logic sec, input logic [Q_W-1:0] ang, input logic [Q_W-1:0] edist,
			input logic [Q_W-1:0] mag);
		plan_entry_t req;
		req           = '0;
		req.kind      = REQ_SAMPLE;
		req.smp.id    = id;
		req.smp.step  = step;
		req.smp.sec   = sec;
		req.smp.ang   = ang;
		req.smp.edist = edist;
		req.smp.mag   = mag;
		pending_requests.push_back(req);
	endtask

	task automatic plan_config(input logic [1:0] idx, input logic [Q_W-1:0] data);
		plan_entry_t req;
		req      = '0;
		req.kind = REQ_CONFIG;
		req.idx  = idx;
		req.data = data;
		pending_requests.push_back(req);
	endtask

	task automatic plan_drain();
		plan_entry_t req;
		req      = '0;
		req.kind = REQ_DRAIN;
		pending_requests.push_back(req);
	endtask

	// Random part of one configuration phase. Most samples belong to a few
	// tracked objects with rising step numbers and values that wander in a
	// narrow window, so three-point extrema come up often and the magnitude
	// sits on both sides of any limit within 2^30 of zero. The rest are fully random samples.
	task automatic plan_track_phase(input int count, input int limit);
		int center;
		int slot;
		logic [Q_W-1:0] mag;
		if (limit > (1 << 30) || limit < -(1 << 30)) begin
			center = 0;
		end else begin
			center = limit;
		end
		for (int t = 0; t < TRACKS; t++) begin
			track_obj[t]  = ID_W'($urandom);
			track_step[t] = '0;
			track_ang[t]  = $urandom;
			track_dist[t] = $urandom;
		end
		// The lowest and highest object index always have a track, and one
		// track runs into the saturated top of the step range.
		track_obj[0]  = '0;
		track_obj[1]  = '1;
		track_step[1] = STEP_W'(16'hFFF8);
		for (int n = 0; n < count; n++) begin
			if ($urandom_range(99) < 20) begin
				plan_sample(ID_W'($urandom), STEP_W'($urandom), 1'($urandom),
					$urandom, $urandom, $urandom);
			end else begin
				slot = $urandom_range(TRACKS - 1);
				if ($urandom_range(59) == 0) begin
					track_step[slot] = '0;
				end else if (track_step[slot] != '1) begin
					track_step[slot] = track_step[slot] + 1'b1;
				end
				mag = center + (int'($urandom_range(12)) - 6) * (Q_ONE / 2);
				plan_sample(track_obj[slot], track_step[slot], $urandom_range(9) != 0,
					track_ang[slot] + (int'($urandom_range(8)) - 4) * (Q_ONE / 4),
					track_dist[slot] + (int'($urandom_range(8)) - 4) * (Q_ONE / 4),
					mag);
			end
		end
	endtask

	// Driver: presents the plan on the sample and register channels. Valid is
	// computed once per edge and assigned once, so a request that follows
	// straight on from the one just accepted keeps valid high without a glitch.
	always @(posedge clk or negedge arst_n) begin : request_driver
		plan_entry_t req;
		logic        acc_in;
		logic        acc_cfg;
		logic        nxt_in_valid;
		logic        nxt_cfg_valid;
		int          outstanding;
		int          gap_left;
		int          quiet_cycles;
		if (!arst_n) begin
			in_valid       <= 1'b0;
			cfg_valid      <= 1'b0;
			cfg_index      <= '0;
			cfg_data       <= '0;
			object_id      <= '0;
			step_index     <= '0;
			secure         <= 1'b0;
			sun_angle      <= '0;
			earth_distance <= '0;
			magnitude      <= '0;
			sent_count     <= 0;
			gap_left     = 0;
			quiet_cycles = 0;
		end else begin
			acc_in  = in_valid && in_ready;
			acc_cfg = cfg_valid && cfg_ready;
			nxt_in_valid  = in_valid && !acc_in;
			nxt_cfg_valid = cfg_valid && !acc_cfg;
			outstanding = sent_count + int'(acc_in) - got_count;
			if (acc_in) begin
				sent_count <= sent_count + 1;
			end
			quiet_cycles = (outstanding == 0) ? quiet_cycles + 1 : 0;

			if (!nxt_in_valid && !nxt_cfg_valid) begin
				if (gap_left != 0) begin
					gap_left--;
				end else if (pending_requests.size() != 0) begin
					req = pending_requests[0];
					case (req.kind)
						REQ_SAMPLE: begin
							void'(pending_requests.pop_front());
							object_id      <= req.smp.id;
							step_index     <= req.smp.step;
							secure         <= req.smp.sec;
							sun_angle      <= req.smp.ang;
							earth_distance <= req.smp.edist;
							magnitude      <= req.smp.mag;
							nxt_in_valid = 1'b1;
							gap_left = pick_gap(((sent_count >> 7) % 3) == 1);
						end
						// Registers change only once every result is back and the
						// block has had a few cycles to settle.
						REQ_CONFIG: begin
							if (outstanding == 0 && quiet_cycles >= SETTLE_CYCLES) begin
								void'(pending_requests.pop_front());
								cfg_index <= req.idx;
								cfg_data  <= req.data;
								nxt_cfg_valid = 1'b1;
							end
						end
						// The sender pauses here until the block has run dry.
						default: begin
							if (outstanding == 0) begin
								void'(pending_requests.pop_front());
							end
						end
					endcase
				end
			end
			in_valid  <= nxt_in_valid;
			cfg_valid <= nxt_cfg_valid;
		end
	end

	// Monitor: predicts each accepted sample, applies each accepted register
	// write to the shadow, checks each accepted result and drives out_ready.
	// Results are checked before this edge's sample is predicted; a result can
	// never belong to a sample taken at the same edge.
	always @(posedge clk or negedge arst_n) begin : result_monitor
		result_t want;
		int      gap;
		int      hold_left;
		int      stall_left;
		bit      hold_done;
		if (!arst_n) begin
			for (int i = 0; i < OBJECTS; i++) begin
				ang_last[i]     = Q_800;
				ang_prev[i]     = Q_900;
				dist_last[i]    = Q_900;
				dist_prev[i]    = Q_800;
				mag_last[i]     = Q_900;
				mag_prev[i]     = Q_800;
				in_selection[i] = 1'b0;
			end
			selection_total = '0;
			bright_limit = MAG_LIMIT_RST;
			report_on    = 1'b0;
			collect_on   = 1'b1;
			out_ready <= 1'b0;
			got_count <= 0;
			hold_left  = 0;
			stall_left = 0;
			hold_done  = 1'b0;
		end else begin
			if (out_valid && out_ready) begin
				got_count <= got_count + 1;
				if (detections_due.size() == 0) begin
					$display("%0t ns: result for object %0d arrived with no sample waiting",
						$time, result_object);
					error_count++;
				end else begin
					want = detections_due.pop_front();
					check_field("result_object", want.obj, Q_W'(want.obj),
						Q_W'(result_object));
					check_field("opposition", want.obj, Q_W'(want.opp), Q_W'(opposition));
					check_field("apogee", want.obj, Q_W'(want.apo), Q_W'(apogee));
					check_field("peak_brightness", want.obj, Q_W'(want.peak),
						Q_W'(peak_brightness));
					check_field("bright", want.obj, Q_W'(want.bright), Q_W'(bright));
					check_field("newly_selected", want.obj, Q_W'(want.fresh),
						Q_W'(newly_selected));
					check_field("selected_count", want.obj, Q_W'(want.count),
						Q_W'(selected_count));
					check_field("reported_magnitude", want.obj, want.mag, reported_magnitude);
					check_field("reported_distance", want.obj, want.edist, reported_distance);
					bright_total += want.bright;
					fresh_total  += want.fresh;
					event_total  += want.opp + want.apo + want.peak;
				end
			end

			if (cfg_valid && cfg_ready) begin
				config_count++;
				case (cfg_index)
					REG_MAG_LIMIT: bright_limit = cfg_data;
					REG_REPORT:    report_on    = cfg_data[0];
					REG_COLLECT:   collect_on   = cfg_data[0];
					default: ;
				endcase
			end

			if (in_valid && in_ready) begin
				detections_due.push_back(predict_detection({object_id, step_index, secure,
					sun_angle, earth_distance, magnitude}));
			end

			// One long hold-off, while the sender keeps offering, fills the
			// pipeline and must push back on the sample channel. Otherwise
			// the receiver stalls at random after each result it takes.
			if (hold_left != 0) begin
				hold_left--;
				out_ready <= (hold_left == 0);
			end else if (!hold_done && got_count == HOLD_AT_RESULT) begin
				hold_done = 1'b1;
				hold_left = HOLD_CYCLES;
				out_ready <= 1'b0;
			end else if (stall_left != 0) begin
				stall_left--;
				out_ready <= (stall_left == 0);
			end else if (!out_ready || out_valid) begin
				gap = pick_gap(((got_count >> 7) % 3) == 2);
				stall_left = gap;
				out_ready <= (gap == 0);
			end
		end
	end

	initial begin : run_control
		int limit;
		arst_n = 1'b0;

		// Directed part, first with the reset settings: reporting off, limit
		// 12.0, collection on.
		// A sample that is not secure changes nothing.
		plan_sample(12'd5, 16'd10, 1'b0, 32'(Q_ONE), 32'(Q_ONE), 32'(Q_ONE));
		// Step numbers on both sides of the threshold of two.
		plan_sample(12'd0, 16'd0, 1'b1, 32'(Q_ONE), 32'(Q_ONE), 32'(Q_ONE));
		plan_sample(12'd0, 16'd2, 1'b1, 32'(Q_ONE), 32'(Q_ONE), 32'(Q_ONE));
		plan_sample(12'd0, 16'd3, 1'b1, 32'(Q_ONE), 32'(Q_ONE), 32'(Q_ONE));
		// The same object again is already in the selection map.
		plan_sample(12'd0, 16'd4, 1'b1, 32'(2 * Q_ONE), 32'(Q_ONE), 32'(Q_ONE));
		// Magnitude equal to the limit is not bright, one LSB below is.
		plan_sample(12'd4095, 16'hFFFF, 1'b1, '0, '0, MAG_LIMIT_RST);
		plan_sample(12'd4095, 16'hFFFF, 1'b1, '0, '0, MAG_LIMIT_RST - 1);
		// Extremes of the Q16.16 fields.
		plan_sample(12'd1, 16'd100, 1'b1, 32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000);
		plan_sample(12'd1, 16'd101, 1'b1, 32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF);

		plan_config(REG_REPORT, flag_word(1'b1));
		// A fresh object's first bright sample sees the reset history, which
		// makes a distance maximum out of any smaller distance.
		plan_sample(12'd9, 16'd3, 1'b1, 32'(10 * Q_ONE), 32'(10 * Q_ONE), 32'(5 * Q_ONE));
		plan_sample(12'd9, 16'd4, 1'b1, 32'(20 * Q_ONE), 32'(20 * Q_ONE), 32'(1 * Q_ONE));
		// Not secure in the middle of the sequence: the history must hold.
		plan_sample(12'd9, 16'd5, 1'b0, '0, '0, '0);
		// All three events at once.
		plan_sample(12'd9, 16'd6, 1'b1, 32'(15 * Q_ONE), 32'(15 * Q_ONE), 32'(3 * Q_ONE));
		// Equal neighbours are not extrema.
		plan_sample(12'd9, 16'd7, 1'b1, 32'(15 * Q_ONE), 32'(15 * Q_ONE), 32'(3 * Q_ONE));
		plan_sample(12'd9, 16'd8, 1'b1, 32'(14 * Q_ONE), 32'(16 * Q_ONE), 32'(2 * Q_ONE));
		// Secure but too faint: history shifts, no events despite a minimum.
		plan_sample(12'd9, 16'd9, 1'b1, 32'(13 * Q_ONE), 32'(13 * Q_ONE), 32'(20 * Q_ONE));
		plan_sample(12'd9, 16'd10, 1'b1, 32'(12 * Q_ONE), 32'(12 * Q_ONE), 32'(4 * Q_ONE));

		// With collection off a bright object is not selected.
		plan_config(REG_COLLECT, flag_word(1'b0));
		plan_sample(12'd77, 16'd3, 1'b1, '0, '0, 32'(Q_ONE));
		// Limit at the top: nearly everything is bright.
		plan_config(REG_COLLECT, flag_word(1'b1));
		plan_config(REG_MAG_LIMIT, 32'h7FFF_FFFF);
		plan_sample(12'd78, 16'd3, 1'b1, '0, '0, 32'h7FFF_FFFE);
		// Limit at the bottom: nothing can be bright.
		plan_config(REG_MAG_LIMIT, 32'h8000_0000);
		plan_sample(12'd79, 16'd3, 1'b1, '0, '0, 32'h8000_0000);
		// A write to the unused index must leave every register alone.
		plan_config(REG_UNUSED, $urandom);
		plan_sample(12'd80, 16'd3, 1'b1, '0, '0, 32'h8000_0000);

		// Random part, one configuration per phase. The long receiver hold-off
		// falls into the first phase, which has no pause in it.
		plan_config(REG_MAG_LIMIT, MAG_LIMIT_RST);
		plan_config(REG_REPORT, flag_word(1'b1));
		plan_track_phase(400, MAG_LIMIT_RST);

		plan_config(REG_MAG_LIMIT, 32'h7FFF_FFFF);
		plan_config(REG_COLLECT, flag_word(1'b0));
		plan_config(REG_UNUSED, $urandom);
		plan_track_phase(350, 32'h7FFF_FFFF);

		plan_config(REG_MAG_LIMIT, 32'h8000_0000);
		plan_config(REG_REPORT, flag_word(1'b0));
		plan_config(REG_COLLECT, flag_word(1'b1));
		plan_track_phase(250, 32'h8000_0000);

		limit = $urandom;
		plan_config(REG_MAG_LIMIT, limit);
		plan_config(REG_REPORT, flag_word(1'b1));
		plan_track_phase(200, limit);
		plan_drain();
		plan_track_phase(200, limit);

		plan_config(REG_MAG_LIMIT, 32'(-5 * Q_ONE));
		plan_config(REG_COLLECT, flag_word(1'b0));
		plan_track_phase(160, -5 * Q_ONE);
		plan_drain();
		plan_track_phase(170, -5 * Q_ONE);

		repeat (2) @(posedge clk);
		arst_n <= 1'b1;

		while (pending_requests.size() != 0 || in_valid || cfg_valid
				|| sent_count != got_count) begin
			@(negedge clk);
		end
		repeat (TAIL_CYCLES) @(negedge clk);

		if (detections_due.size() != 0) begin
			$display("%0t ns: %0d predicted results never arrived", $time,
				detections_due.size());
		end
		$display("Checked %0d samples over %0d register writes, limits at both extremes.",
			got_count, config_count);
		$display("Bright %0d, newly selected %0d, extremum events %0d, mismatches %0d.",
			bright_total, fresh_total, event_total, error_count);
		if (error_count == 0 && detections_due.size() == 0) begin
			$display("TEST PASSED");
		end else begin
			$display("TEST FAILED");
		end
		$finish;
	end

	// Watchdog: the history clearing pass plus every sample at its worst gaps
	// and stalls stays far below this.
	initial begin : watchdog
		#2_000_000;
		$display("%0t ns: run did not finish, %0d samples sent, %0d results seen",
			$time, sent_count, got_count);
		$display("TEST FAILED");
		$finish;
	end

endmodule
